>>> src/c8x_pkg.sv
`timescale 1ns / 1ps
package c8x_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNIMPL    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_LOADED    = 3'd4;

  localparam int unsigned ADDR_W = 12;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_BULK,
    S_BULK_LAST,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;   // write zero at the clear address, advance
    logic capture;      // latch the input item
    logic exec;         // perform a non-bulk instruction or byte load
    logic bulk_step;    // one register of FX55/FX65
    logic bulk_last;    // final FX65 read data write-back
    logic out_load;     // load the result register
  } c8x_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic is_bulk;      // captured item is FX55 or FX65
    logic bulk_end;     // current bulk step is register X
    logic bulk_read;    // FX65 (needs a trailing write-back)
  } c8x_stat_t;

endpackage

>>> src/c8x_ctrl.sv
`timescale 1ns / 1ps
module c8x_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  c8x_pkg::c8x_stat_t st,
  output c8x_pkg::c8x_cmd_t  cmd
);

  c8x_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Hold state and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= c8x_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Sequence one item at a time
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      c8x_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) state_nxt = c8x_pkg::S_IDLE;
      end
      c8x_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = c8x_pkg::S_EXEC;
        end
      end
      c8x_pkg::S_EXEC: begin
        if (st.is_bulk) begin
          state_nxt = c8x_pkg::S_BULK;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = c8x_pkg::S_DONE;
        end
      end
      c8x_pkg::S_BULK: begin
        cmd.bulk_step = 1'b1;
        if (st.bulk_end)
          state_nxt = st.bulk_read ? c8x_pkg::S_BULK_LAST : c8x_pkg::S_DONE;
      end
      c8x_pkg::S_BULK_LAST: begin
        cmd.bulk_last = 1'b1;
        state_nxt     = c8x_pkg::S_DONE;
      end
      c8x_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = c8x_pkg::S_IDLE;
        end
      end
      default: state_nxt = c8x_pkg::S_IDLE;
    endcase
  end

endmodule

>>> src/c8x_dpath.sv
`timescale 1ns / 1ps
module c8x_dpath #(
  parameter int unsigned MEM_BYTES   = 4096,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  c8x_pkg::c8x_cmd_t  cmd,
  output c8x_pkg::c8x_stat_t st,
  input  logic               in_op,
  input  logic [15:0]        in_instr_word,
  input  logic [11:0]        in_load_addr,
  input  logic [7:0]         in_load_byte,
  output logic [11:0]        out_pc_after,
  output logic [15:0]        out_index_after,
  output logic [7:0]         out_delay_after,
  output logic [7:0]         out_sound_after,
  output logic [2:0]         out_status
);

  localparam int unsigned MA_W = $clog2(MEM_BYTES);
  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SI_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Architectural state
  logic [7:0]            vreg_r [16];
  logic [11:0]           pc_r;
  logic [15:0]           index_r;
  logic [SP_W-1:0]       sp_r;
  logic [11:0]           stack_r [STACK_DEPTH];
  logic [7:0]            delay_r;
  logic [7:0]            sound_r;
  logic [7:0]            mem_r [MEM_BYTES];
  logic [7:0]            mem_rd_r;

  // Captured item and walk state
  logic                  op_r;
  logic [15:0]           word_r;
  logic [11:0]           laddr_r;
  logic [7:0]            lbyte_r;
  logic [2:0]            status_r;
  logic [MA_W:0]         clr_r;
  logic [3:0]            bi_r;
  logic [3:0]            wb_idx_r;

  logic [3:0]  x, y;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn, skip_pc;
  logic [8:0]  sum;

  assign x       = word_r[11:8];
  assign y       = word_r[7:4];
  assign kk      = word_r[7:0];
  assign nnn     = word_r[11:0];
  assign vx      = vreg_r[x];
  assign vy      = vreg_r[y];
  assign sum     = {1'b0, vx} + {1'b0, vy};
  assign skip_pc = pc_r + 12'd2;

  assign st.clear_done = clr_r[MA_W-1:0] == MA_W'(MEM_BYTES - 1);
  assign st.is_bulk    = !op_r && word_r[15:12] == 4'hF &&
                         (kk == 8'h55 || kk == 8'h65);
  assign st.bulk_end   = bi_r == x;
  assign st.bulk_read  = kk == 8'h65;

  logic [MA_W-1:0] bulk_addr;
  assign bulk_addr = MA_W'(index_r[11:0] + {8'd0, bi_r});

  // Memory: clear sweep, byte load, bulk store, bulk read
  always_ff @(posedge clk) begin
    if (cmd.clear_step) mem_r[clr_r[MA_W-1:0]] <= 8'd0;
    else if (cmd.exec && op_r) mem_r[MA_W'(laddr_r)] <= lbyte_r;
    else if (cmd.bulk_step && !st.bulk_read) mem_r[bulk_addr] <= vreg_r[bi_r];
    mem_rd_r <= mem_r[bulk_addr];
  end

  // Clear counter, capture, walk index
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear_step) clr_r <= clr_r + 1'b1;
    if (cmd.capture) begin
      op_r    <= in_op;
      word_r  <= in_instr_word;
      laddr_r <= in_load_addr;
      lbyte_r <= in_load_byte;
      bi_r    <= 4'd0;
    end
    if (cmd.bulk_step) begin
      bi_r     <= bi_r + 4'd1;
      wb_idx_r <= bi_r;
    end
  end

  // Execute: registers and status
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      for (int i = 0; i < 16; i++) vreg_r[i] <= 8'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stack_r[i] <= 12'd0;
      pc_r    <= 12'd0;
      index_r <= 16'd0;
      sp_r    <= '0;
      delay_r <= 8'd0;
      sound_r <= 8'd0;
    end
    if (cmd.bulk_step) begin
      if (st.bulk_read && bi_r != 4'd0) vreg_r[wb_idx_r] <= mem_rd_r;
      status_r <= c8x_pkg::ST_OK;
    end
    if (cmd.bulk_last) vreg_r[wb_idx_r] <= mem_rd_r;
    if (cmd.exec) begin
      status_r <= c8x_pkg::ST_OK;
      if (op_r) begin
        status_r <= c8x_pkg::ST_LOADED;
      end else begin
        case (word_r[15:12])
          4'h0: begin
            if (word_r != 16'h00EE) status_r <= c8x_pkg::ST_UNIMPL;
            else if (sp_r == '0) status_r <= c8x_pkg::ST_UNDERFLOW;
            else begin
              sp_r <= sp_r - 1'b1;
              pc_r <= stack_r[SI_W'(sp_r - 1'b1)];
            end
          end
          4'h1: pc_r <= nnn;
          4'h2: begin
            if (sp_r >= SP_W'(STACK_DEPTH)) status_r <= c8x_pkg::ST_OVERFLOW;
            else begin
              stack_r[SI_W'(sp_r)] <= pc_r;
              sp_r <= sp_r + 1'b1;
              pc_r <= nnn;
            end
          end
          4'h3: if (vx == kk) pc_r <= skip_pc;
          4'h4: if (vx != kk) pc_r <= skip_pc;
          4'h5: if (vx == vy) pc_r <= skip_pc;
          4'h6: vreg_r[x] <= kk;
          4'h7: vreg_r[x] <= vx + kk;
          4'h8: begin
            case (word_r[3:0])
              4'h0: vreg_r[x] <= vy;
              4'h1: vreg_r[x] <= vx | vy;
              4'h2: vreg_r[x] <= vx & vy;
              4'h3: vreg_r[x] <= vx ^ vy;
              4'h4: begin
                vreg_r[x]  <= sum[7:0];
                vreg_r[15] <= {7'd0, sum[8]};
              end
              default: status_r <= c8x_pkg::ST_UNIMPL;
            endcase
          end
          4'h9: if (vx != vy) pc_r <= skip_pc;
          4'hA: index_r <= {4'd0, nnn};
          4'hB: pc_r <= nnn + {4'd0, vreg_r[0]};
          4'hF: begin
            case (kk)
              8'h07: vreg_r[x] <= delay_r;
              8'h15: delay_r <= vx;
              8'h18: sound_r <= vx;
              8'h1E: index_r <= index_r + {8'd0, vx};
              default: status_r <= c8x_pkg::ST_UNIMPL;
            endcase
          end
          default: status_r <= c8x_pkg::ST_UNIMPL;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pc_after    <= pc_r;
      out_index_after <= index_r;
      out_delay_after <= delay_r;
      out_sound_after <= sound_r;
      out_status      <= status_r;
    end
  end

endmodule

>>> src/chip8_instruction_execute.sv
`timescale 1ns / 1ps
// Channel | Ports                                                  | Direction
// in      | in_valid in_stall in_op in_instr_word in_load_addr     | into block
//         | in_load_byte                                           |
// out     | out_valid out_stall out_pc_after out_index_after       | out of block
//         | out_delay_after out_sound_after out_status             |
// Items go EXEC then DONE; FX55/FX65 walk V0..VX in BULK instead (one memory byte a cycle).
// After reset a clearing pass zeroes memory before any item.
// One item is in flight; the next is taken once its result sits in the output register.
// out_stall holds the result; the block then waits before loading the next one.
module chip8_instruction_execute #(
  parameter int unsigned MEM_BYTES   = 4096,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_instr_word,
  input  logic [11:0] in_load_addr,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pc_after,
  output logic [15:0] out_index_after,
  output logic [7:0]  out_delay_after,
  output logic [7:0]  out_sound_after,
  output logic [2:0]  out_status
);

  c8x_pkg::c8x_cmd_t  cmd;
  c8x_pkg::c8x_stat_t st;

  // Sequencer
  c8x_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .cmd
  );

  // State and memory
  c8x_dpath #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dpath (
    .clk, .rst_n, .cmd, .st, .in_op, .in_instr_word, .in_load_addr, .in_load_byte,
    .out_pc_after, .out_index_after, .out_delay_after, .out_sound_after,
    .out_status
  );

endmodule
